[rtl/keyed_metric_table_top_macros.svh]
// ----------------------------------------------------------------------------
// keyed_metric_table_top_macros.svh
// assertion macros shared by the metric table rtl
// ----------------------------------------------------------------------------
`ifndef KEYED_METRIC_TABLE_TOP_MACROS_SVH
`define KEYED_METRIC_TABLE_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define KMT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define KMT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/kmt_pkg.sv]
// ----------------------------------------------------------------------------
// kmt_pkg
// sizes, operation and status codes and beat types of the metric table
// ----------------------------------------------------------------------------
package kmt_pkg;

    // table geometry
    localparam int ENTRIES  = 32;
    localparam int BUCKETS  = 8;
    localparam int KEY_BITS = 32;

    localparam int SLOT_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int BKT_W   = $clog2(BUCKETS);
    localparam int BADDR_W = ((ENTRIES * BUCKETS) > 1) ? $clog2(ENTRIES * BUCKETS) : 1;

    // operation codes
    localparam logic [2:0] OP_ADD     = 3'd0;
    localparam logic [2:0] OP_SET     = 3'd1;
    localparam logic [2:0] OP_OBSERVE = 3'd2;
    localparam logic [2:0] OP_RD_VAL  = 3'd3;
    localparam logic [2:0] OP_RD_BKT  = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_MISS = 2'd2;

    // request beat
    typedef struct packed {
        logic [2:0]         op;
        logic [31:0]        key;
        logic signed [63:0] amount;
        logic [2:0]         bucket_sel;
    } kmt_req_t;

    // response beat
    typedef struct packed {
        logic [1:0]         status;
        logic signed [63:0] result_value;
    } kmt_rsp_t;

    // decade search status
    typedef struct packed {
        logic             done;
        logic [BKT_W-1:0] bucket;
    } kmt_dec_t;

endpackage

[rtl/kmt_ram.sv]
// ----------------------------------------------------------------------------
// kmt_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module kmt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                                        clk,
    input  logic                                        wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                            wr_data,
    input  logic                                        rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                            rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/kmt_decade.sv]
// ----------------------------------------------------------------------------
// kmt_decade
// iterative decade search: one threshold compare and one times-ten per cycle
// ----------------------------------------------------------------------------
module kmt_decade
    import kmt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [63:0] sample,
    output kmt_dec_t           res
);

    localparam logic [BKT_W-1:0] BKT_LAST = BKT_W'(BUCKETS - 1);

    logic               busy_reg, busy_next;
    logic signed [63:0] sample_reg, sample_next;
    logic signed [63:0] thr_reg, thr_next;
    logic [BKT_W-1:0]   bkt_reg, bkt_next;
    logic               step;

    // another decade step while below the last bucket and the sample reaches the threshold
    assign step = (bkt_reg < BKT_LAST) && (sample_reg >= thr_reg);

    always_comb
    begin
        busy_next   = busy_reg;
        sample_next = sample_reg;
        thr_next    = thr_reg;
        bkt_next    = bkt_reg;
        if (start)
        begin
            busy_next   = 1'b1;
            sample_next = sample;
            thr_next    = 64'sd1;
            bkt_next    = '0;
        end
        else if (busy_reg)
        begin
            if (step)
            begin
                // times ten as two shifted adds
                thr_next = (thr_reg <<< 3) + (thr_reg <<< 1);
                bkt_next = bkt_reg + 1'b1;
            end
            else
            begin
                busy_next = 1'b0;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
        thr_reg    <= thr_next;
        bkt_reg    <= bkt_next;
    end

    assign res.done   = busy_reg && !step;
    assign res.bucket = bkt_reg;

endmodule

[rtl/keyed_metric_table_top.sv]
// ----------------------------------------------------------------------------
// keyed_metric_table_top
// keyed metric table with value and decade histogram per entry
// ----------------------------------------------------------------------------
// Usage: a request beat on req (req_valid/req_ready) carries an operation, a
// key, a signed amount and a bucket selector; exactly one response beat on
// rsp (rsp_valid/rsp_ready) answers it with a status and a 64-bit value.
// The block takes one request at a time: req_ready is high only while idle.
// A key scan reads and compares the stored keys one after another, since the
// key ram has one read port; a read that misses, or an update that finds the
// table full, answers from there. A new key is written and its histogram row
// is zeroed bucket by bucket. An observe runs the decade search on its amount;
// then the value is read and written, an observe also updates its bucket, and
// the response register is loaded before the block returns to idle. An
// undefined operation goes straight to loading the response register.
// Reset empties the table at once: no clearing pass runs, and values and
// buckets of a new key read as zero. A stalled response stays in the output
// register; the next request is taken as soon as the block is idle again, and
// its response waits until the earlier one has been taken.
// ----------------------------------------------------------------------------
`include "keyed_metric_table_top_macros.svh"

module keyed_metric_table_top
    import kmt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  kmt_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output kmt_rsp_t rsp
);

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_SCAN_RD  = 9'b000000010,
        S_SCAN_CMP = 9'b000000100,
        S_CLEAR    = 9'b000001000,
        S_DECADE   = 9'b000010000,
        S_RD       = 9'b000100000,
        S_WR       = 9'b001000000,
        S_BKT_WR   = 9'b010000000,
        S_DONE     = 9'b100000000
    } state_t;

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(ENTRIES);
    localparam logic [BKT_W-1:0] BKT_LAST = BKT_W'(BUCKETS - 1);

    state_t                state_reg, state_next;
    logic [2:0]            op_reg, op_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic signed [63:0]    amt_reg, amt_next;
    logic [2:0]            sel_reg, sel_next;
    logic [CNT_W-1:0]      idx_reg, idx_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [SLOT_W-1:0]     slot_reg, slot_next;
    logic                  fresh_reg, fresh_next;
    logic [BKT_W-1:0]      bkt_reg, bkt_next;
    logic [BKT_W-1:0]      clr_reg, clr_next;
    logic [1:0]            status_reg, status_next;
    logic signed [63:0]    value_reg, value_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    kmt_rsp_t              rsp_reg, rsp_next;

    // ram ports
    logic                  key_wr_en, key_rd_en;
    logic [SLOT_W-1:0]     key_wr_addr, key_rd_addr;
    logic [KEY_BITS-1:0]   key_rd_data;
    logic                  val_wr_en, val_rd_en;
    logic [63:0]           val_wr_data, val_rd_data;
    logic                  bkt_wr_en, bkt_rd_en;
    logic [BADDR_W-1:0]    bkt_addr;
    logic [63:0]           bkt_wr_data, bkt_rd_data;

    // shared adder and decade unit
    logic [63:0]           add_a, add_b, add_sum;
    logic                  dec_start;
    kmt_dec_t              dec_res;
    logic                  go_disp;
    logic                  is_read;
    logic                  sel_ok;
    logic [63:0]           old_value;

    // terms for the checks
    logic                  chk_full_load;
    logic                  chk_miss_beat;

    assign add_sum   = add_a + add_b;
    assign is_read   = (op_reg == OP_RD_VAL) || (op_reg == OP_RD_BKT);
    assign sel_ok    = (32'(sel_reg) < BUCKETS);
    assign old_value = fresh_reg ? 64'd0 : val_rd_data;

    // histogram word address of a slot and bucket
    function automatic logic [BADDR_W-1:0] row_addr(logic [SLOT_W-1:0] s, logic [BKT_W-1:0] b);
        return BADDR_W'(s) * BADDR_W'(BUCKETS) + BADDR_W'(b);
    endfunction

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        amt_next       = amt_reg;
        sel_next       = sel_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        slot_next      = slot_reg;
        fresh_next     = fresh_reg;
        bkt_next       = bkt_reg;
        clr_next       = clr_reg;
        status_next    = status_reg;
        value_next     = value_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;

        key_wr_en   = 1'b0;
        key_wr_addr = count_reg[SLOT_W-1:0];
        key_rd_en   = 1'b0;
        key_rd_addr = idx_reg[SLOT_W-1:0];
        val_wr_en   = 1'b0;
        val_wr_data = add_sum;
        val_rd_en   = 1'b0;
        bkt_wr_en   = 1'b0;
        bkt_wr_data = add_sum;
        bkt_rd_en   = 1'b0;
        bkt_addr    = row_addr(slot_reg, bkt_reg);
        add_a       = old_value;
        add_b       = amt_reg;
        dec_start   = 1'b0;
        go_disp     = 1'b0;

        // response register drains
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next     = req.op;
                    key_next    = KEY_BITS'(req.key);
                    amt_next    = req.amount;
                    sel_next    = req.bucket_sel;
                    idx_next    = '0;
                    fresh_next  = 1'b0;
                    status_next = ST_OK;
                    value_next  = '0;
                    if (req.op > OP_RD_BKT)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SCAN_RD;
                    end
                end
            end
            S_SCAN_RD:
            begin
                if (idx_reg == count_reg)
                begin
                    // key absent
                    if (is_read)
                    begin
                        status_next = ST_MISS;
                        value_next  = '1;
                        state_next  = S_DONE;
                    end
                    else if (count_reg == CNT_FULL)
                    begin
                        status_next = ST_FULL;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        key_wr_en  = 1'b1;
                        slot_next  = count_reg[SLOT_W-1:0];
                        count_next = count_reg + 1'b1;
                        fresh_next = 1'b1;
                        clr_next   = '0;
                        state_next = S_CLEAR;
                    end
                end
                else
                begin
                    key_rd_en  = 1'b1;
                    state_next = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP:
            begin
                if (key_rd_data == key_reg)
                begin
                    slot_next = idx_reg[SLOT_W-1:0];
                    go_disp   = 1'b1;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_SCAN_RD;
                end
            end
            S_CLEAR:
            begin
                // zero the new entry's histogram row
                bkt_wr_en   = 1'b1;
                bkt_addr    = row_addr(slot_reg, clr_reg);
                bkt_wr_data = '0;
                if (clr_reg == BKT_LAST)
                begin
                    go_disp = 1'b1;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            S_DECADE:
            begin
                if (dec_res.done)
                begin
                    bkt_next   = dec_res.bucket;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                val_rd_en  = 1'b1;
                bkt_rd_en  = 1'b1;
                state_next = S_WR;
            end
            S_WR:
            begin
                state_next = S_DONE;
                case (op_reg)
                    OP_ADD:
                    begin
                        val_wr_en = 1'b1;
                    end
                    OP_SET:
                    begin
                        val_wr_en   = 1'b1;
                        val_wr_data = amt_reg;
                    end
                    OP_OBSERVE:
                    begin
                        add_b      = 64'd1;
                        val_wr_en  = 1'b1;
                        state_next = S_BKT_WR;
                    end
                    OP_RD_VAL:
                    begin
                        value_next = old_value;
                    end
                    default:
                    begin
                        value_next = bkt_rd_data;
                    end
                endcase
            end
            S_BKT_WR:
            begin
                add_a      = bkt_rd_data;
                add_b      = 64'd1;
                bkt_wr_en  = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next        = 1'b1;
                    rsp_next.status       = status_reg;
                    rsp_next.result_value = value_reg;
                    state_next            = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // entry found or added: pick the work for the operation
        if (go_disp)
        begin
            if (op_reg == OP_OBSERVE)
            begin
                dec_start  = 1'b1;
                state_next = S_DECADE;
            end
            else if ((op_reg == OP_RD_BKT) && !sel_ok)
            begin
                state_next = S_DONE;
            end
            else
            begin
                bkt_next   = BKT_W'(sel_reg);
                state_next = S_RD;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload and work registers
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        key_reg    <= key_next;
        amt_reg    <= amt_next;
        sel_reg    <= sel_next;
        idx_reg    <= idx_next;
        slot_reg   <= slot_next;
        fresh_reg  <= fresh_next;
        bkt_reg    <= bkt_next;
        clr_reg    <= clr_next;
        status_reg <= status_next;
        value_reg  <= value_next;
        rsp_reg    <= rsp_next;
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // stored keys
    kmt_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (ENTRIES)
    ) u_key_ram (
        .clk     (clk),
        .wr_en   (key_wr_en),
        .wr_addr (key_wr_addr),
        .wr_data (key_reg),
        .rd_en   (key_rd_en),
        .rd_addr (key_rd_addr),
        .rd_data (key_rd_data)
    );

    // entry values
    kmt_ram #(
        .WIDTH (64),
        .DEPTH (ENTRIES)
    ) u_val_ram (
        .clk     (clk),
        .wr_en   (val_wr_en),
        .wr_addr (slot_reg),
        .wr_data (val_wr_data),
        .rd_en   (val_rd_en),
        .rd_addr (slot_reg),
        .rd_data (val_rd_data)
    );

    // histogram buckets
    kmt_ram #(
        .WIDTH (64),
        .DEPTH (ENTRIES * BUCKETS)
    ) u_bkt_ram (
        .clk     (clk),
        .wr_en   (bkt_wr_en),
        .wr_addr (bkt_addr),
        .wr_data (bkt_wr_data),
        .rd_en   (bkt_rd_en),
        .rd_addr (bkt_addr),
        .rd_data (bkt_rd_data)
    );

    // decade search unit
    kmt_decade u_decade (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (dec_start),
        .sample (amt_reg),
        .res    (dec_res)
    );

    // checks
    assign chk_full_load = rsp_valid_next && !rsp_valid_reg && (rsp_next.status == ST_FULL);
    assign chk_miss_beat = rsp_valid && (rsp.status == ST_MISS);

    `KMT_ASSERT_IMP(a_count_range, 1'b1, count_reg <= CNT_FULL, "entry count beyond table size")
    `KMT_ASSERT_IMP(a_full_only_full, chk_full_load, count_reg == CNT_FULL, "full status with room")
    `KMT_ASSERT_IMP(a_miss_value, chk_miss_beat, &rsp.result_value, "miss value not all ones")
    `KMT_ASSERT_IMP(a_decade_range, dec_res.done, dec_res.bucket <= BKT_LAST, "bucket out of range")
    `KMT_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "taken while busy")

endmodule
